[rtl/core/fef_pkg.sv]
package fef_pkg;

   localparam int CRD_W          = 8;
   localparam int HEAT_W         = 8;
   localparam int SEED_W         = 16;
   localparam int CFG_DIM_W      = 5;
   localparam int CFG_SCALE_W    = 8;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;
   localparam int DEF_MAX_WIDTH  = 16;
   localparam int DEF_MAX_HEIGHT = 16;

   localparam logic [SEED_W-1:0] SEED_RESET = 16'd1337;
   localparam logic [SEED_W-1:0] SEED_MUL   = 16'd2053;
   localparam logic [SEED_W-1:0] SEED_ADD   = 16'd13849;

   localparam logic [HEAT_W-1:0] OFFSET_BOUND = 8'd128;
   localparam logic [4:0]        OFFSET_MAX   = 5'd16;
   localparam logic [HEAT_W-1:0] SPARK_TOP    = 8'd240;

   localparam logic [CFG_DIM_W-1:0]   DIM_RESET   = 5'd16;
   localparam logic [CFG_SCALE_W-1:0] SCALE_RESET = 8'd255;

   localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
   localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
   localparam logic [2:0] REG_SCALE_RED   = 3'd2;
   localparam logic [2:0] REG_SCALE_GREEN = 3'd3;
   localparam logic [2:0] REG_SCALE_BLUE  = 3'd4;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef logic [4:0] dp_cmd_type;

   localparam dp_cmd_type CMD_NOP     = 5'd0;
   localparam dp_cmd_type CMD_CLR     = 5'd1;
   localparam dp_cmd_type CMD_ACCEPT  = 5'd2;
   localparam dp_cmd_type CMD_STEP    = 5'd3;
   localparam dp_cmd_type CMD_OFFSET  = 5'd4;
   localparam dp_cmd_type CMD_COOL_RD = 5'd5;
   localparam dp_cmd_type CMD_COOL_LM = 5'd6;
   localparam dp_cmd_type CMD_COOL_WR = 5'd7;
   localparam dp_cmd_type CMD_DIF_B   = 5'd8;
   localparam dp_cmd_type CMD_DIF_L   = 5'd9;
   localparam dp_cmd_type CMD_DIF_R   = 5'd10;
   localparam dp_cmd_type CMD_DIF_W   = 5'd11;
   localparam dp_cmd_type CMD_SPK_N   = 5'd12;
   localparam dp_cmd_type CMD_SPK_COL = 5'd13;
   localparam dp_cmd_type CMD_SPK_CUR = 5'd14;
   localparam dp_cmd_type CMD_SPK_WR  = 5'd15;
   localparam dp_cmd_type CMD_RD_ADDR = 5'd16;
   localparam dp_cmd_type CMD_RD_PAL  = 5'd17;
   localparam dp_cmd_type CMD_RD_OUT  = 5'd18;

   typedef struct packed {
      logic clr_last;
      logic cool_last;
      logic dif_last;
      logic dif_skip;
      logic spk_zero;
   } dp_status_type;

endpackage

[rtl/core/fef_ram.sv]
module fef_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 256,
     localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic             clock,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/fef_ctrl.sv]
module fef_ctrl
   import fef_pkg::*;
   (input  logic          clock,
    input  logic          reset,
    input  logic          start,
    input  logic          operation,
    input  dp_status_type status,
    output dp_cmd_type    cmd,
    output logic          busy);

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_OFF_STEP = 5'd2;
   localparam logic [4:0] S_OFFSET   = 5'd3;
   localparam logic [4:0] S_COOL_RD  = 5'd4;
   localparam logic [4:0] S_COOL_LM  = 5'd5;
   localparam logic [4:0] S_COOL_WR  = 5'd6;
   localparam logic [4:0] S_DIF_B    = 5'd7;
   localparam logic [4:0] S_DIF_L    = 5'd8;
   localparam logic [4:0] S_DIF_R    = 5'd9;
   localparam logic [4:0] S_DIF_W    = 5'd10;
   localparam logic [4:0] S_N_STEP   = 5'd11;
   localparam logic [4:0] S_SPK_N    = 5'd12;
   localparam logic [4:0] S_SPK_CHK  = 5'd13;
   localparam logic [4:0] S_COL_STEP = 5'd14;
   localparam logic [4:0] S_SPK_COL  = 5'd15;
   localparam logic [4:0] S_SPK_CUR  = 5'd16;
   localparam logic [4:0] S_SPK_WR   = 5'd17;
   localparam logic [4:0] S_RD_ADDR  = 5'd18;
   localparam logic [4:0] S_RD_PAL   = 5'd19;
   localparam logic [4:0] S_RD_OUT   = 5'd20;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NOP;
      unique case (state_ff)
         S_CLEAR: begin
            cmd = CMD_CLR;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd      = CMD_ACCEPT;
               state_in = (operation == OP_READ) ? S_RD_ADDR : S_OFF_STEP;
            end
         end
         S_OFF_STEP: begin
            cmd      = CMD_STEP;
            state_in = S_OFFSET;
         end
         S_OFFSET: begin
            cmd      = CMD_OFFSET;
            state_in = S_COOL_RD;
         end
         S_COOL_RD: begin
            cmd      = CMD_COOL_RD;
            state_in = S_COOL_LM;
         end
         S_COOL_LM: begin
            cmd      = CMD_COOL_LM;
            state_in = S_COOL_WR;
         end
         S_COOL_WR: begin
            cmd = CMD_COOL_WR;
            if (!status.cool_last) state_in = S_COOL_RD;
            else if (status.dif_skip) state_in = S_N_STEP;
            else state_in = S_DIF_B;
         end
         S_DIF_B: begin
            cmd      = CMD_DIF_B;
            state_in = S_DIF_L;
         end
         S_DIF_L: begin
            cmd      = CMD_DIF_L;
            state_in = S_DIF_R;
         end
         S_DIF_R: begin
            cmd      = CMD_DIF_R;
            state_in = S_DIF_W;
         end
         S_DIF_W: begin
            cmd      = CMD_DIF_W;
            state_in = status.dif_last ? S_N_STEP : S_DIF_B;
         end
         S_N_STEP: begin
            cmd      = CMD_STEP;
            state_in = S_SPK_N;
         end
         S_SPK_N: begin
            cmd      = CMD_SPK_N;
            state_in = S_SPK_CHK;
         end
         S_SPK_CHK: begin
            state_in = status.spk_zero ? S_IDLE : S_COL_STEP;
         end
         S_COL_STEP: begin
            cmd      = CMD_STEP;
            state_in = S_SPK_COL;
         end
         S_SPK_COL: begin
            cmd      = CMD_SPK_COL;
            state_in = S_SPK_CUR;
         end
         S_SPK_CUR: begin
            cmd      = CMD_SPK_CUR;
            state_in = S_SPK_WR;
         end
         S_SPK_WR: begin
            cmd      = CMD_SPK_WR;
            state_in = S_SPK_CHK;
         end
         S_RD_ADDR: begin
            cmd      = CMD_RD_ADDR;
            state_in = S_RD_PAL;
         end
         S_RD_PAL: begin
            cmd      = CMD_RD_PAL;
            state_in = S_RD_OUT;
         end
         S_RD_OUT: begin
            cmd      = CMD_RD_OUT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[rtl/core/fef_datapath.sv]
module fef_datapath
   import fef_pkg::*;
   #(parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
     parameter int MAX_HEIGHT = DEF_MAX_HEIGHT)
   (input  logic                   clock,
    input  logic                   reset,
    input  dp_cmd_type             cmd,
    output dp_status_type          status,
    input  logic [CFG_DIM_W-1:0]   grid_width,
    input  logic [CFG_DIM_W-1:0]   grid_height,
    input  logic [CFG_SCALE_W-1:0] scale_red,
    input  logic [CFG_SCALE_W-1:0] scale_green,
    input  logic [CFG_SCALE_W-1:0] scale_blue,
    input  logic [7:0]             pixel_index,
    output logic                   rsp_valid,
    output logic [7:0]             rsp_red,
    output logic [7:0]             rsp_green,
    output logic [7:0]             rsp_blue);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [15:0]      CELLS_W = 16'(CELLS);
   localparam logic [CRD_W-1:0] MAXW_C  = CRD_W'(MAX_WIDTH);
   localparam logic [CRD_W-1:0] MAXH_C  = CRD_W'(MAX_HEIGHT);

   logic [SEED_W-1:0] seed_ff;
   logic [SEED_W-1:0] seed_next;
   logic [AW-1:0]     clr_ff;
   logic              valid_ff;
   logic [CRD_W-1:0]  w_ff, h_ff, x_ff, y_ff, n_ff, col_ff;
   logic [AW-1:0]     idx_ff, rb_ff, pix_ff;
   logic              pix_ok_ff;
   logic [4:0]        offset_ff;
   logic [HEAT_W-1:0] v_ff, lim_ff, b_ff, bl_ff, cur_ff;
   logic [7:0]        r_ff, g_ff, bb_ff, red_ff, green_ff, blue_ff;

   logic [CRD_W-1:0]  w_in, h_in, xl, xr, w_last, h_last;
   logic [HEAT_W-1:0] bound, draw, rnd, frac, lim_in, t, t192, ramp, spark_room;
   logic [15:0]       prod;
   logic [11:0]       lim_raw;
   logic [9:0]        t3;
   logic [16:0]       prod_r, prod_g, prod_b;
   logic [15:0]       pix16;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [HEAT_W-1:0] ram_wdata, ram_rdata;

   fef_ram #(.WIDTH(HEAT_W), .DEPTH(CELLS)) u_heat_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata));

   assign seed_next = seed_ff * SEED_MUL + SEED_ADD;
   assign draw      = seed_ff[7:0] + seed_ff[15:8];
   assign prod      = draw * bound;
   assign rnd       = prod[15:8];

   assign w_last = w_ff - 1'b1;
   assign h_last = h_ff - 1'b1;
   assign xl     = (x_ff == '0) ? w_last : x_ff - 1'b1;
   assign xr     = (x_ff == w_last) ? '0 : x_ff + 1'b1;

   assign w_in = (grid_width == '0) ? CRD_W'(1) :
                 (CRD_W'(grid_width) > MAXW_C) ? MAXW_C : CRD_W'(grid_width);
   assign h_in = (grid_height == '0) ? CRD_W'(1) :
                 (CRD_W'(grid_height) > MAXH_C) ? MAXH_C : CRD_W'(grid_height);

   assign pix16 = 16'(pixel_index);

   assign frac    = {2'b00, ram_rdata[7:2]} + {1'b0, ram_rdata[7:1]};
   assign lim_raw = {(9'(offset_ff) + 9'(y_ff)), 3'b000};
   assign lim_in  = (lim_raw < 12'(frac)) ? lim_raw[7:0] : frac;

   assign spark_room = SPARK_TOP - cur_ff;

   assign t    = pix_ok_ff ? ram_rdata : '0;
   assign t3   = 10'(t) + {1'b0, t, 1'b0};
   assign t192 = t3[9:2] + ((t != '0) ? 8'd1 : 8'd0);
   assign ramp = {t192[5:0], 2'b00};

   assign prod_r = r_ff  * (9'(scale_red)   + 9'd1);
   assign prod_g = g_ff  * (9'(scale_green) + 9'd1);
   assign prod_b = bb_ff * (9'(scale_blue)  + 9'd1);

   always_comb begin
      bound     = '0;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = '0;
      ram_raddr = idx_ff;
      unique case (cmd)
         CMD_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
         end
         CMD_OFFSET:  bound = OFFSET_BOUND;
         CMD_COOL_WR: begin
            bound     = lim_ff;
            ram_we    = 1'b1;
            ram_wdata = v_ff - rnd;
         end
         CMD_DIF_B: ram_raddr = rb_ff + AW'(x_ff);
         CMD_DIF_L: ram_raddr = rb_ff + AW'(xl);
         CMD_DIF_R: ram_raddr = rb_ff + AW'(xr);
         CMD_DIF_W: begin
            ram_we    = 1'b1;
            ram_waddr = rb_ff + AW'(w_ff) + AW'(x_ff);
            ram_wdata = {1'b0, b_ff[7:1]} + {2'b00, bl_ff[7:2]} + {2'b00, ram_rdata[7:2]};
         end
         CMD_SPK_N: bound = {1'b0, w_ff[CRD_W-1:1]};
         CMD_SPK_COL: begin
            bound     = w_ff;
            ram_raddr = AW'(rnd);
         end
         CMD_SPK_WR: begin
            bound     = spark_room;
            ram_we    = 1'b1;
            ram_waddr = AW'(col_ff);
            ram_wdata = cur_ff + rnd;
         end
         CMD_RD_ADDR: ram_raddr = pix_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= SEED_RESET;
         clr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= (cmd == CMD_RD_OUT);
         if (cmd == CMD_CLR) clr_ff <= clr_ff + 1'b1;
         if (cmd == CMD_STEP || cmd == CMD_COOL_RD || cmd == CMD_SPK_CUR) begin
            seed_ff <= seed_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_ACCEPT: begin
            w_ff      <= w_in;
            h_ff      <= h_in;
            pix_ff    <= pix16[AW-1:0];
            pix_ok_ff <= (pix16 < CELLS_W);
         end
         CMD_OFFSET: begin
            offset_ff <= (rnd > 8'(OFFSET_MAX)) ? OFFSET_MAX : rnd[4:0];
            x_ff      <= '0;
            y_ff      <= '0;
            idx_ff    <= '0;
         end
         CMD_COOL_LM: begin
            v_ff   <= ram_rdata;
            lim_ff <= lim_in;
         end
         CMD_COOL_WR: begin
            idx_ff <= idx_ff + 1'b1;
            if (status.cool_last) begin
               x_ff  <= '0;
               y_ff  <= CRD_W'(1);
               rb_ff <= '0;
            end else if (x_ff == w_last) begin
               x_ff <= '0;
               y_ff <= y_ff + 1'b1;
            end else begin
               x_ff <= x_ff + 1'b1;
            end
         end
         CMD_DIF_L: b_ff  <= ram_rdata;
         CMD_DIF_R: bl_ff <= ram_rdata;
         CMD_DIF_W: begin
            if (y_ff == h_last) begin
               y_ff  <= CRD_W'(1);
               rb_ff <= '0;
               x_ff  <= x_ff + 1'b1;
            end else begin
               y_ff  <= y_ff + 1'b1;
               rb_ff <= rb_ff + AW'(w_ff);
            end
         end
         CMD_SPK_N:   n_ff   <= rnd;
         CMD_SPK_COL: col_ff <= rnd;
         CMD_SPK_CUR: cur_ff <= ram_rdata;
         CMD_SPK_WR:  n_ff   <= n_ff - 1'b1;
         CMD_RD_PAL: begin
            if (t192[7]) begin
               r_ff  <= 8'hFF;
               g_ff  <= 8'hFF;
               bb_ff <= ramp;
            end else if (t192[6]) begin
               r_ff  <= 8'hFF;
               g_ff  <= ramp;
               bb_ff <= '0;
            end else begin
               r_ff  <= ramp;
               g_ff  <= '0;
               bb_ff <= '0;
            end
         end
         CMD_RD_OUT: begin
            red_ff   <= prod_r[15:8];
            green_ff <= prod_g[15:8];
            blue_ff  <= prod_b[15:8];
         end
         default: begin
         end
      endcase
   end

   assign status.clr_last  = (clr_ff == AW'(CELLS - 1));
   assign status.cool_last = (x_ff == w_last) && (y_ff == h_last);
   assign status.dif_last  = (x_ff == w_last) && (y_ff == h_last);
   assign status.dif_skip  = (h_ff == CRD_W'(1));
   assign status.spk_zero  = (n_ff == '0);

   assign rsp_valid = valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

[rtl/core/fire_effect_frame_engine_unit.sv]
// read transaction: RD_ADDR, RD_PAL, RD_OUT, then the strobe; busy until done
// update transaction: busy through cooling, diffusion and n sparks, n below w/2,
//   with cell visits sharing the heat memory and serial prng draws
// result strobe lasts one cycle, receiver cannot stall
// synchronous reset; afterwards busy stays high while all MAX_WIDTH*MAX_HEIGHT
//   heat memory cells are cleared one cell per cycle
module fire_effect_frame_engine_unit
   import fef_pkg::*;
   #(parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
     parameter int MAX_HEIGHT = DEF_MAX_HEIGHT)
   (input  logic                  clock,
    input  logic                  reset,
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_operation,
    input  logic [7:0]            req_pixel_index,
    output logic                  rsp_valid,
    output logic [7:0]            rsp_red,
    output logic [7:0]            rsp_green,
    output logic [7:0]            rsp_blue,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CSR_ADDR_W-1:0] paddr,
    input  logic [CSR_DATA_W-1:0] pwdata,
    output logic [CSR_DATA_W-1:0] prdata,
    output logic                  pready);

   logic [CFG_DIM_W-1:0]   grid_width_ff, grid_height_ff;
   logic [CFG_SCALE_W-1:0] scale_red_ff, scale_green_ff, scale_blue_ff;
   logic                   csr_wr;
   dp_cmd_type             cmd;
   dp_status_type          status;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= DIM_RESET;
         grid_height_ff <= DIM_RESET;
         scale_red_ff   <= SCALE_RESET;
         scale_green_ff <= SCALE_RESET;
         scale_blue_ff  <= SCALE_RESET;
      end else if (csr_wr) begin
         unique case (paddr[4:2])
            REG_GRID_WIDTH:  grid_width_ff  <= pwdata[CFG_DIM_W-1:0];
            REG_GRID_HEIGHT: grid_height_ff <= pwdata[CFG_DIM_W-1:0];
            REG_SCALE_RED:   scale_red_ff   <= pwdata[CFG_SCALE_W-1:0];
            REG_SCALE_GREEN: scale_green_ff <= pwdata[CFG_SCALE_W-1:0];
            REG_SCALE_BLUE:  scale_blue_ff  <= pwdata[CFG_SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_GRID_WIDTH:  prdata = CSR_DATA_W'(grid_width_ff);
         REG_GRID_HEIGHT: prdata = CSR_DATA_W'(grid_height_ff);
         REG_SCALE_RED:   prdata = CSR_DATA_W'(scale_red_ff);
         REG_SCALE_GREEN: prdata = CSR_DATA_W'(scale_green_ff);
         REG_SCALE_BLUE:  prdata = CSR_DATA_W'(scale_blue_ff);
         default:         prdata = '0;
      endcase
   end

   fef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy));

   fef_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .scale_red   (scale_red_ff),
      .scale_green (scale_green_ff),
      .scale_blue  (scale_blue_ff),
      .pixel_index (req_pixel_index),
      .rsp_valid   (rsp_valid),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue));

endmodule

[rtl/core/fef_checker.sv]
module fef_checker
   (input logic clock,
    input logic reset,
    input logic start,
    input logic busy,
    input logic req_operation,
    input logic rsp_valid);

   // clearing pass holds off transactions right after reset
   assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_operation |=> !rsp_valid)
      else $error("update transaction produced a result");

endmodule

bind fire_effect_frame_engine_unit fef_checker u_fef_checker (.*);
